>>> hw/rtl/omd_pkg.sv
// omd_pkg: shared types, constants and the letter table of the optical morse decoder
// no dependencies; imported by every other file of the block
`default_nettype none

package omd_pkg;

  // channel and register widths
  localparam int unsigned SampleWidth = 10;
  localparam int unsigned MsWidth     = 16;
  localparam int unsigned KindWidth   = 3;
  localparam int unsigned CharWidth   = 7;
  localparam int unsigned StableWidth = 17;
  localparam int unsigned SinceWidth  = 18;

  // configuration port
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] RegLevelThreshold = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegInvertLevel    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegDebounce       = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegDashThreshold  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegLetterGap      = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegWordGap        = 3'd5;

  // register reset values
  localparam logic [SampleWidth-1:0] LevelThresholdRst = 10'd400;
  localparam logic                   InvertLevelRst    = 1'b0;
  localparam logic [MsWidth-1:0]     DebounceRst       = 16'd50;
  localparam logic [MsWidth-1:0]     DashThresholdRst  = 16'd300;
  localparam logic [MsWidth-1:0]     LetterGapRst      = 16'd500;
  localparam logic [MsWidth-1:0]     WordGapRst        = 16'd1500;

  // saturation limits of the timers
  localparam logic [StableWidth-1:0] StableMax = '1;
  localparam logic [SinceWidth-1:0]  SinceMax  = '1;

  // symbol buffer default depth
  localparam int unsigned MaxSymbolsDefault = 6;
  // longest pattern present in the letter table
  localparam int unsigned TableMaxLen = 5;

  // output queue depth, holds two full ticks of results
  localparam int unsigned FifoDepth = 4;

  localparam logic [CharWidth-1:0] CharUnknown = 7'h3F;  // '?'
  localparam logic [CharWidth-1:0] CharNone    = 7'h00;

  typedef enum logic [KindWidth-1:0] {
    KIND_DOT    = 3'd0,
    KIND_DASH   = 3'd1,
    KIND_LETTER = 3'd2,
    KIND_SPACE  = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [SampleWidth-1:0] level_threshold;
    logic                   invert_level;
    logic [MsWidth-1:0]     debounce_ms;
    logic [MsWidth-1:0]     dash_threshold_ms;
    logic [MsWidth-1:0]     letter_gap_ms;
    logic [MsWidth-1:0]     word_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [CharWidth-1:0] character;
    logic                 last;
  } result_t;

  // up to two results written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // pattern bit i is symbol i, 1 = dash; bits beyond len are zero
  function automatic logic [CharWidth-1:0] decode_char(logic [2:0] len, logic [4:0] bits);
    logic [CharWidth-1:0] ch;
    case ({len, bits})
      {3'd2, 5'd2}:  ch = 7'h41;  // A
      {3'd4, 5'd1}:  ch = 7'h42;  // B
      {3'd4, 5'd5}:  ch = 7'h43;  // C
      {3'd3, 5'd1}:  ch = 7'h44;  // D
      {3'd1, 5'd0}:  ch = 7'h45;  // E
      {3'd4, 5'd4}:  ch = 7'h46;  // F
      {3'd3, 5'd3}:  ch = 7'h47;  // G
      {3'd4, 5'd0}:  ch = 7'h48;  // H
      {3'd2, 5'd0}:  ch = 7'h49;  // I
      {3'd4, 5'd14}: ch = 7'h4A;  // J
      {3'd3, 5'd5}:  ch = 7'h4B;  // K
      {3'd4, 5'd2}:  ch = 7'h4C;  // L
      {3'd2, 5'd3}:  ch = 7'h4D;  // M
      {3'd2, 5'd1}:  ch = 7'h4E;  // N
      {3'd3, 5'd7}:  ch = 7'h4F;  // O
      {3'd4, 5'd6}:  ch = 7'h50;  // P
      {3'd4, 5'd11}: ch = 7'h51;  // Q
      {3'd3, 5'd2}:  ch = 7'h52;  // R
      {3'd3, 5'd0}:  ch = 7'h53;  // S
      {3'd1, 5'd1}:  ch = 7'h54;  // T
      {3'd3, 5'd4}:  ch = 7'h55;  // U
      {3'd4, 5'd8}:  ch = 7'h56;  // V
      {3'd3, 5'd6}:  ch = 7'h57;  // W
      {3'd4, 5'd9}:  ch = 7'h58;  // X
      {3'd4, 5'd13}: ch = 7'h59;  // Y
      {3'd4, 5'd3}:  ch = 7'h5A;  // Z
      {3'd5, 5'd30}: ch = 7'h31;  // 1
      {3'd5, 5'd28}: ch = 7'h32;  // 2
      {3'd5, 5'd24}: ch = 7'h33;  // 3
      {3'd5, 5'd16}: ch = 7'h34;  // 4
      {3'd5, 5'd0}:  ch = 7'h35;  // 5
      {3'd5, 5'd1}:  ch = 7'h36;  // 6
      {3'd5, 5'd3}:  ch = 7'h37;  // 7
      {3'd5, 5'd7}:  ch = 7'h38;  // 8
      {3'd5, 5'd15}: ch = 7'h39;  // 9
      {3'd5, 5'd31}: ch = 7'h30;  // 0
      default:       ch = CharUnknown;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/omd_sample_if.sv
// omd_sample_if: valid/ready channel carrying one sensor sample per tick
// depends on omd_pkg
`default_nettype none

interface omd_sample_if import omd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/omd_result_if.sv
// omd_result_if: valid/ready channel carrying one decoded result
// depends on omd_pkg
`default_nettype none

interface omd_result_if import omd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KindWidth-1:0] kind;
  logic [CharWidth-1:0] character;
  logic                 last;

  modport source (output valid, output kind, output character, output last, input ready);
  modport sink   (input valid, input kind, input character, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/omd_tracker.sv
// omd_tracker: threshold, debounce, edge timing and symbol buffer of the decoder
// depends on omd_pkg; produces up to two results per processed tick
`default_nettype none

module omd_tracker import omd_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MaxSymbolsDefault
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     step_i,
  input  wire  [SampleWidth-1:0]  sample_i,
  input  cfg_t                    cfg_i,
  output push_t                   push_o
);

  localparam int unsigned CntWidth = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned IdxWidth = $clog2(MAX_SYMBOLS);
  localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_SYMBOLS);
  localparam logic [CntWidth-1:0] CntTableMax = CntWidth'(TableMaxLen);

  logic                   prev_level_q, prev_level_d;
  logic [StableWidth-1:0] stable_q, stable_d;
  logic                   acc_level_q, acc_level_d;
  logic [SinceWidth-1:0]  since_q, since_d;
  logic [CntWidth-1:0]    count_q, count_d;
  logic [MAX_SYMBOLS-1:0] pattern_q, pattern_d;
  logic                   overflow_q, overflow_d;
  logic                   done_q, done_d;

  logic                   level;
  logic [SinceWidth-1:0]  since_inc;
  logic                   is_dash;
  logic [CharWidth-1:0]   letter_char;
  push_t                  push;

  always_comb begin
    if (overflow_q || count_q > CntTableMax) begin
      letter_char = CharUnknown;
    end else begin
      letter_char = decode_char(count_q[2:0], pattern_q[4:0]);
    end
  end

  always_comb begin
    if (cfg_i.invert_level) begin
      level = sample_i < cfg_i.level_threshold;
    end else begin
      level = sample_i > cfg_i.level_threshold;
    end

    if (level != prev_level_q) begin
      stable_d = '0;
    end else if (stable_q != StableMax) begin
      stable_d = stable_q + 1'b1;
    end else begin
      stable_d = stable_q;
    end
    prev_level_d = level;

    since_inc = (since_q != SinceMax) ? since_q + 1'b1 : since_q;

    acc_level_d = (stable_d > {1'b0, cfg_i.debounce_ms}) ? level : acc_level_q;
    is_dash     = since_inc > {2'b00, cfg_i.dash_threshold_ms};

    since_d    = since_inc;
    count_d    = count_q;
    pattern_d  = pattern_q;
    overflow_d = overflow_q;
    done_d     = done_q;
    push       = '0;

    if (acc_level_d != acc_level_q) begin
      since_d = '0;
      done_d  = 1'b0;
      if (acc_level_q) begin
        // falling edge closes an on-time
        if (count_q < CntMax) begin
          pattern_d[count_q[IdxWidth-1:0]] = is_dash;
          count_d = count_q + 1'b1;
        end else begin
          overflow_d = 1'b1;
        end
        push.count = 2'd1;
        push.first = '{kind: is_dash ? KIND_DASH : KIND_DOT, character: CharNone, last: 1'b1};
      end else if (count_q != '0 && since_inc > {2'b00, cfg_i.letter_gap_ms}) begin
        count_d    = '0;
        pattern_d  = '0;
        overflow_d = 1'b0;
        push.first = '{kind: KIND_LETTER, character: letter_char, last: 1'b1};
        push.count = 2'd1;
        if (since_inc > {2'b00, cfg_i.word_gap_ms}) begin
          push.count      = 2'd2;
          push.first.last = 1'b0;
          push.second     = '{kind: KIND_SPACE, character: CharNone, last: 1'b1};
        end
      end
    end else if (since_inc > {1'b0, cfg_i.word_gap_ms, 1'b0}) begin
      // quiet period: flush the pending letter once
      if (!done_q && count_q != '0) begin
        count_d     = '0;
        pattern_d   = '0;
        overflow_d  = 1'b0;
        done_d      = 1'b1;
        push.count  = 2'd2;
        push.first  = '{kind: KIND_LETTER, character: letter_char, last: 1'b0};
        push.second = '{kind: KIND_END, character: CharNone, last: 1'b1};
      end
    end
  end

  assign push_o = step_i ? push : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      stable_q     <= '0;
      acc_level_q  <= 1'b0;
      since_q      <= '0;
      count_q      <= '0;
      pattern_q    <= '0;
      overflow_q   <= 1'b0;
      done_q       <= 1'b0;
    end else if (step_i) begin
      prev_level_q <= prev_level_d;
      stable_q     <= stable_d;
      acc_level_q  <= acc_level_d;
      since_q      <= since_d;
      count_q      <= count_d;
      pattern_q    <= pattern_d;
      overflow_q   <= overflow_d;
      done_q       <= done_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/omd_out_fifo.sv
// omd_out_fifo: small result queue taking up to two results per cycle
// depends on omd_pkg
`default_nettype none

module omd_out_fifo import omd_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  push_t    push_i,
  output logic     room2_o,
  output logic     valid_o,
  input  wire      ready_i,
  output result_t  data_o
);

  localparam int unsigned PtrWidth = $clog2(FifoDepth);
  localparam int unsigned LvlWidth = $clog2(FifoDepth + 1);
  localparam logic [LvlWidth-1:0] RoomLimit = LvlWidth'(FifoDepth - 2);

  result_t             mem_q [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LvlWidth-1:0] level_q, level_d;
  logic [PtrWidth-1:0] wr_ptr_next;
  logic                pop;

  assign valid_o     = level_q != '0;
  assign data_o      = mem_q[rd_ptr_q];
  assign room2_o     = level_q <= RoomLimit;
  assign pop         = valid_o && ready_i;
  assign wr_ptr_next = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrWidth'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrWidth'(pop);
    level_d  = level_q + LvlWidth'(push_i.count) - LvlWidth'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/optical_morse_decoder.sv
// optical_morse_decoder: top level, configuration registers, input register and wiring
// depends on omd_pkg, omd_sample_if, omd_result_if, omd_tracker, omd_out_fifo
`default_nettype none

// Decodes Morse code from a light sensor. Each sample transfer is one millisecond
// tick; the sample is thresholded (optionally inverted), debounced, and the accepted
// level is timed. A falling edge yields a dot or dash, a rising edge after a letter
// gap yields the decoded letter ('?' if unknown) plus a word space past the word gap,
// and a quiet period of twice the word gap flushes the pending letter followed by an
// end marker. Each tick gives zero, one or two results; last marks the final one.
// Rate: one sample per clock. A sample is held in the input register, then the
// tracker updates its state and writes its results into a four-entry output queue in
// the same cycle, and the queue offers them from its registered entries. A
// sample is processed only while the queue has room for two results, so the sink
// must sustain one result per cycle for the block to keep taking samples each cycle.
// Configuration writes take effect on the next tick and should be made while idle.
module optical_morse_decoder import omd_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MaxSymbolsDefault
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire  [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire  [CfgDataWidth-1:0] cfg_data_i,
  omd_sample_if.sink              in_ch,
  omd_result_if.source            out_ch
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_threshold   <= LevelThresholdRst;
      cfg_q.invert_level      <= InvertLevelRst;
      cfg_q.debounce_ms       <= DebounceRst;
      cfg_q.dash_threshold_ms <= DashThresholdRst;
      cfg_q.letter_gap_ms     <= LetterGapRst;
      cfg_q.word_gap_ms       <= WordGapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLevelThreshold: cfg_q.level_threshold   <= cfg_data_i[SampleWidth-1:0];
        RegInvertLevel:    cfg_q.invert_level      <= cfg_data_i[0];
        RegDebounce:       cfg_q.debounce_ms       <= cfg_data_i;
        RegDashThreshold:  cfg_q.dash_threshold_ms <= cfg_data_i;
        RegLetterGap:      cfg_q.letter_gap_ms     <= cfg_data_i;
        RegWordGap:        cfg_q.word_gap_ms       <= cfg_data_i;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // input register
  logic                   in_valid_q;
  logic [SampleWidth-1:0] sample_q;
  logic                   room2;
  logic                   step;
  push_t                  push;
  result_t                head;

  // process the held sample when the queue can take two results
  assign step         = in_valid_q && room2;
  assign in_ch.ready  = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_q <= in_ch.sample;
    end
  end

  // level, timing and symbol state
  omd_tracker #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .cfg_i    (cfg_q),
    .push_o   (push)
  );

  // result queue doubles as the output register
  omd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .data_o  (head)
  );

  assign out_ch.kind      = head.kind;
  assign out_ch.character = head.character;
  assign out_ch.last      = head.last;

endmodule

`default_nettype wire
